### sv/cmld_pkg.sv
// ----------------------------------------------------------------------------
// cmld_pkg
// shared types, constants and the default threshold table of the
// calibrated multilevel line decoder
// ----------------------------------------------------------------------------
`default_nettype none

package cmld_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int NUM_LEVELS      = 16;
	localparam int LVL_BITS        = $clog2(NUM_LEVELS);
	localparam int SWEEP_BITS      = LVL_BITS + 1;
	localparam int TABLE_BITS      = 12;

	localparam logic [LVL_BITS-1:0] LAST_STAGE = LVL_BITS'(NUM_LEVELS - 1);
	localparam logic [LVL_BITS-1:0] SKIP_LO    = LVL_BITS'(6);
	localparam logic [LVL_BITS-1:0] SKIP_HI    = LVL_BITS'(9);
	localparam logic [LVL_BITS-1:0] AFTER_LO   = LVL_BITS'(7);
	localparam logic [LVL_BITS-1:0] AFTER_HI   = LVL_BITS'(10);

	typedef enum logic [1:0] {
		CMD_CLASSIFY = 2'd0,
		CMD_RECORD   = 2'd1,
		CMD_RESTORE  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep_en;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic final_rec;
		logic sweep_last;
	} dp_status_t;

	// default table on a 12-bit scale, rescaled to the sample width
	function automatic logic [31:0] default_threshold(input logic [LVL_BITS-1:0] idx,
			input int sb);
		logic [31:0] base;
		unique case (idx)
			4'd0:    base = 32'd1384;
			4'd1:    base = 32'd1523;
			4'd2:    base = 32'd1672;
			4'd3:    base = 32'd1821;
			4'd4:    base = 32'd1960;
			4'd5:    base = 32'd2068;
			4'd6:    base = 32'd2148;
			4'd7:    base = 32'd2336;
			4'd8:    base = 32'd2559;
			4'd9:    base = 32'd2708;
			4'd10:   base = 32'd2863;
			4'd11:   base = 32'd3023;
			4'd12:   base = 32'd3191;
			4'd13:   base = 32'd3382;
			4'd14:   base = 32'd3597;
			default: base = 32'd4096;
		endcase
		return (base << sb) >> TABLE_BITS;
	endfunction

endpackage

`default_nettype wire

### sv/cmld_ctrl.sv
// ----------------------------------------------------------------------------
// cmld_ctrl
// controller: item handshake, threshold sweep sequencing, output valid
// ----------------------------------------------------------------------------
`default_nettype none

module cmld_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	input  wire cmld_pkg::dp_status_t  status,
	output cmld_pkg::ctrl_cmd_t        cmd
);
	import cmld_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_nxt = status.final_rec ? ST_SWEEP : ST_DELIVER;
				end
			end
			ST_SWEEP: begin
				if (status.sweep_last) begin
					state_nxt = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall   = (state_q != ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && item_valid;
		cmd.sweep_en = (state_q == ST_SWEEP);
		cmd.load_out = (state_q == ST_DELIVER) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

### sv/cmld_datapath.sv
// ----------------------------------------------------------------------------
// cmld_datapath
// threshold bank, parallel classifier, calibration readings and the
// midpoint sweep, plus the pending result and output registers
// ----------------------------------------------------------------------------
`default_nettype none

module cmld_datapath #(
	parameter int SAMPLE_BITS = cmld_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmld_pkg::ctrl_cmd_t           cmd,
	output cmld_pkg::dp_status_t               status,
	input  wire logic [1:0]                    command,
	input  wire logic [SAMPLE_BITS-1:0]        sample,
	output logic [cmld_pkg::LVL_BITS-1:0]      level_code,
	output logic [SAMPLE_BITS-1:0]             sample_echo,
	output logic [cmld_pkg::LVL_BITS-1:0]      calib_stage,
	output logic                               calib_done
);
	import cmld_pkg::*;

	localparam int THR_W = SAMPLE_BITS + 1;
	localparam logic [THR_W-1:0] FULL_SCALE = THR_W'(1) << SAMPLE_BITS;

	logic [THR_W-1:0]       thr_q [NUM_LEVELS];
	logic [SAMPLE_BITS-1:0] cal_mem [NUM_LEVELS];
	logic [SAMPLE_BITS-1:0] mem_rd_q;
	logic [SAMPLE_BITS-1:0] last_q;
	logic [SAMPLE_BITS-1:0] avg_lo_q;
	logic [SAMPLE_BITS-1:0] avg_hi_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [LVL_BITS-1:0]    stage_q;
	logic [SWEEP_BITS-1:0]  k_q;

	logic [LVL_BITS-1:0]    res_code_q;
	logic [SAMPLE_BITS-1:0] res_sample_q;
	logic [LVL_BITS-1:0]    res_stage_q;
	logic                   res_done_q;

	logic [LVL_BITS-1:0]    out_code_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic [LVL_BITS-1:0]    out_stage_q;
	logic                   out_done_q;

	logic [LVL_BITS-1:0]    code;
	logic [THR_W-1:0]       sample_ext;
	logic [THR_W-1:0]       avg_sum;
	logic                   is_record;
	logic                   is_restore;
	logic                   skip_stage;
	logic [LVL_BITS-1:0]    k_idx;
	logic [LVL_BITS-1:0]    k_prev_idx;
	logic [LVL_BITS-1:0]    rd_addr;
	logic [SAMPLE_BITS-1:0] rd_reading;
	logic [THR_W-1:0]       rd_ext;
	logic [THR_W:0]         mid_sum;

	assign sample_ext = {1'b0, sample};
	assign is_record  = (command == CMD_RECORD);
	assign is_restore = (command == CMD_RESTORE);
	assign skip_stage = (stage_q == SKIP_LO) || (stage_q == SKIP_HI);
	assign avg_sum    = {1'b0, last_q} + sample_ext;

	// first threshold above the sample, all-ones when none is
	always_comb begin
		code = LAST_STAGE;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (sample_ext < thr_q[i]) begin
				code = LVL_BITS'(i);
			end
		end
	end

	// sweep reads one reading per cycle, skipped stages come from the averages
	assign k_idx      = k_q[LVL_BITS-1:0];
	assign k_prev_idx = k_idx - LVL_BITS'(1);
	// registered read runs one entry ahead of the sweep index
	assign rd_addr    = cmd.accept ? '0 : k_idx + LVL_BITS'(1);

	always_comb begin
		priority if (k_idx == SKIP_LO) begin
			rd_reading = avg_lo_q;
		end else if (k_idx == SKIP_HI) begin
			rd_reading = avg_hi_q;
		end else begin
			rd_reading = mem_rd_q;
		end
	end

	assign rd_ext  = k_q[LVL_BITS] ? FULL_SCALE : {1'b0, rd_reading};
	assign mid_sum = {2'b00, prev_q} + {1'b0, rd_ext};

	assign status.final_rec  = is_record && (stage_q == LAST_STAGE);
	assign status.sweep_last = k_q[LVL_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				thr_q[i] <= THR_W'(default_threshold(LVL_BITS'(i), SAMPLE_BITS));
			end
		end else begin
			if (cmd.accept && is_record) begin
				stage_q <= stage_q + LVL_BITS'(1);
			end else if (cmd.accept && is_restore) begin
				stage_q <= '0;
			end
			if (cmd.accept && is_restore) begin
				for (int i = 0; i < NUM_LEVELS; i++) begin
					thr_q[i] <= THR_W'(default_threshold(LVL_BITS'(i), SAMPLE_BITS));
				end
			end else if (cmd.sweep_en && (k_q != '0)) begin
				thr_q[k_prev_idx] <= mid_sum[THR_W:1];
			end
		end
	end

	// calibration readings and sweep registers
	always_ff @(posedge clk) begin
		if (cmd.accept && is_record) begin
			if (!skip_stage) begin
				cal_mem[stage_q] <= sample;
				last_q           <= sample;
			end
			if (stage_q == AFTER_LO) begin
				avg_lo_q <= avg_sum[THR_W-1:1];
			end
			if (stage_q == AFTER_HI) begin
				avg_hi_q <= avg_sum[THR_W-1:1];
			end
		end
		mem_rd_q <= cal_mem[rd_addr];
		if (cmd.accept) begin
			k_q <= '0;
		end else if (cmd.sweep_en) begin
			k_q    <= k_q + SWEEP_BITS'(1);
			prev_q <= rd_reading;
		end
	end

	// pending result, then the output register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_code_q   <= code;
			res_sample_q <= sample;
			res_done_q   <= status.final_rec;
			if (is_record) begin
				res_stage_q <= stage_q + LVL_BITS'(1);
			end else if (is_restore) begin
				res_stage_q <= '0;
			end else begin
				res_stage_q <= stage_q;
			end
		end
		if (cmd.load_out) begin
			out_code_q   <= res_code_q;
			out_sample_q <= res_sample_q;
			out_stage_q  <= res_stage_q;
			out_done_q   <= res_done_q;
		end
	end

	assign level_code  = out_code_q;
	assign sample_echo = out_sample_q;
	assign calib_stage = out_stage_q;
	assign calib_done  = out_done_q;

endmodule

`default_nettype wire

### sv/calibrated_multilevel_line_decoder.sv
// result path: pending result register at acceptance, output register once free;
//   the record beat that completes calibration passes through the midpoint sweep first
// flow: a new beat is stalled until the last result is loaded into the output register
// reset: arst_n asynchronous active low; thresholds load the default table,
//   stage count clears, calibration readings stay undefined until recorded
// ----------------------------------------------------------------------------
// calibrated_multilevel_line_decoder
// decodes one ladder-voltage sample into a 4-bit line-sensor code against 16
// ascending thresholds; records calibration readings and rebuilds the thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_multilevel_line_decoder #(
	parameter int SAMPLE_BITS = cmld_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input beat
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic [1:0]                 command,
	input  wire logic [SAMPLE_BITS-1:0]     sample,
	// result beat
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [cmld_pkg::LVL_BITS-1:0]   level_code,
	output logic                            front_left,
	output logic                            front_right,
	output logic                            rear_left,
	output logic                            rear_right,
	output logic [SAMPLE_BITS-1:0]          sample_echo,
	output logic [cmld_pkg::LVL_BITS-1:0]   calib_stage,
	output logic                            calib_done
);
	import cmld_pkg::*;

	ctrl_cmd_t  ctl_cmd;
	dp_status_t dp_status;

	// controller: idle -> (sweep) -> deliver, input stalled outside idle
	cmld_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (dp_status),
		.cmd          (ctl_cmd)
	);

	// datapath: classifier, calibration store, midpoint sweep, result registers
	cmld_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl_cmd),
		.status      (dp_status),
		.command     (command),
		.sample      (sample),
		.level_code  (level_code),
		.sample_echo (sample_echo),
		.calib_stage (calib_stage),
		.calib_done  (calib_done)
	);

	// code bits map onto the four sensors, front left is the msb
	assign front_left  = level_code[3];
	assign front_right = level_code[2];
	assign rear_left   = level_code[1];
	assign rear_right  = level_code[0];

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the calibrated multilevel line decoder: drives
// classify, record and restore beats under random sender gaps and receiver
// stalls, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------

module tb_top;

	import cmld_pkg::*;

	localparam int SMP_BITS   = SAMPLE_BITS_DEF;
	localparam int FULL_SCALE = 1 << SMP_BITS;
	localparam int SMP_MAX    = FULL_SCALE - 1;
	localparam int RAND_BEATS = 1050;
	localparam int DRAIN_CYC  = 40;
	localparam int CYCLE_CAP  = 600000;

	// the spare command value behaves like classify
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// one expected result beat
	typedef struct packed {
		logic [3:0]          code;
		logic                fl;
		logic                fr;
		logic                rl;
		logic                rr;
		logic [SMP_BITS-1:0] echo;
		logic [3:0]          stage;
		logic                done;
	} decoded_beat_t;

	// predictor plus store of pending decoded beats
	class decode_scoreboard;
		logic [12:0]         thr [16];
		logic [SMP_BITS-1:0] rd [16];
		logic [3:0]          stage;
		decoded_beat_t       pending [$];
		int                  errors;
		int                  n_classify;
		int                  n_record;
		int                  n_restore;
		int                  n_complete;
		int                  n_checked;

		function void load_table();
			thr[0]  = 13'd1384; thr[1]  = 13'd1523; thr[2]  = 13'd1672; thr[3]  = 13'd1821;
			thr[4]  = 13'd1960; thr[5]  = 13'd2068; thr[6]  = 13'd2148; thr[7]  = 13'd2336;
			thr[8]  = 13'd2559; thr[9]  = 13'd2708; thr[10] = 13'd2863; thr[11] = 13'd3023;
			thr[12] = 13'd3191; thr[13] = 13'd3382; thr[14] = 13'd3597; thr[15] = 13'd4096;
		endfunction

		function new();
			load_table();
			foreach (rd[i])
				rd[i] = '0;
			stage = '0;
			errors = 0;
			n_classify = 0;
			n_record = 0;
			n_restore = 0;
			n_complete = 0;
			n_checked = 0;
		endfunction

		function logic [3:0] level_of(logic [SMP_BITS-1:0] smp);
			for (int i = 0; i < 16; i++) begin
				if ({1'b0, smp} < thr[i])
					return 4'(i);
			end
			return 4'd15;
		endfunction

		function void note_beat(logic [1:0] cmd, logic [SMP_BITS-1:0] smp);
			decoded_beat_t e;
			int nxt;
			e.code = level_of(smp);
			e.done = 1'b0;
			if (cmd == CMD_RECORD) begin
				n_record++;
				// stages 6 and 9 ignore the sample and copy the previous reading
				if (stage == 4'd6 || stage == 4'd9)
					rd[stage] = rd[stage - 4'd1];
				else
					rd[stage] = smp;
				if (stage == 4'd15) begin
					rd[6] = SMP_BITS'((int'(rd[5]) + int'(rd[7])) >> 1);
					rd[9] = SMP_BITS'((int'(rd[8]) + int'(rd[10])) >> 1);
					for (int i = 0; i < 16; i++) begin
						nxt = (i < 15) ? int'(rd[i + 1]) : FULL_SCALE;
						thr[i] = 13'((int'(rd[i]) + nxt) >> 1);
					end
					e.done = 1'b1;
					n_complete++;
				end
				stage = stage + 4'd1;
			end else if (cmd == CMD_RESTORE) begin
				n_restore++;
				load_table();
				stage = '0;
			end else begin
				n_classify++;
			end
			e.fl = e.code[3];
			e.fr = e.code[2];
			e.rl = e.code[1];
			e.rr = e.code[0];
			e.echo = smp;
			e.stage = stage;
			pending.push_back(e);
		endfunction

		function void cmp_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(decoded_beat_t act);
			decoded_beat_t e;
			if (pending.size() == 0) begin
				$error("result beat with no expectation pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			cmp_field("level_code", e.code, act.code);
			cmp_field("front_left", e.fl, act.fl);
			cmp_field("front_right", e.fr, act.fr);
			cmp_field("rear_left", e.rl, act.rl);
			cmp_field("rear_right", e.rr, act.rr);
			cmp_field("sample_echo", e.echo, act.echo);
			cmp_field("calib_stage", e.stage, act.stage);
			cmp_field("calib_done", e.done, act.done);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	logic [1:0]          command;
	logic [SMP_BITS-1:0] sample;
	logic                result_valid;
	logic                result_stall;
	logic [3:0]          level_code;
	logic                front_left;
	logic                front_right;
	logic                rear_left;
	logic                rear_right;
	logic [SMP_BITS-1:0] sample_echo;
	logic [3:0]          calib_stage;
	logic                calib_done;

	decode_scoreboard sb;
	int               cycle_count;
	int               beats_sent;
	int               burst_left;
	int               stall_mode;
	int               stall_hold;

	calibrated_multilevel_line_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.level_code   (level_code),
		.front_left   (front_left),
		.front_right  (front_right),
		.rear_left    (rear_left),
		.rear_right   (rear_right),
		.sample_echo  (sample_echo),
		.calib_stage  (calib_stage),
		.calib_done   (calib_done)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog: a generous cycle cap ends a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("calibrated_multilevel_line_decoder verification failed");
			$finish;
		end
	end

	// monitor: both handshakes seen with pre-edge values at the rising edge;
	// the input beat is noted first so a same-edge result still pops the oldest
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (item_valid && !item_stall)
				sb.note_beat(command, sample);
			if (result_valid && !result_stall)
				sb.check_result({level_code, front_left, front_right, rear_left,
					rear_right, sample_echo, calib_stage, calib_done});
		end
	end

	// receiver backpressure: the pattern is redrawn at random, switching
	// between no stall, coin toss, light stall, periodic and long holds
	initial begin
		result_stall = 1'b0;
		stall_mode = 0;
		stall_hold = 0;
	end
	always @(negedge clk) begin
		if (cycle_count % 200 == 0)
			stall_mode <= $urandom_range(0, 4);
		case (stall_mode)
			0: begin
				result_stall <= 1'b0;
			end
			1: begin
				result_stall <= $urandom_range(0, 1);
			end
			2: begin
				result_stall <= ($urandom_range(0, 3) == 0);
			end
			3: begin
				result_stall <= (cycle_count % 5) < 3;
			end
			default: begin
				// occasional long holds, their length drawn at random
				if (stall_hold > 0) begin
					stall_hold <= stall_hold - 1;
					result_stall <= 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					stall_hold <= $urandom_range(1, 12);
					result_stall <= 1'b1;
				end else begin
					result_stall <= 1'b0;
				end
			end
		endcase
	end

	// one beat: present at the falling edge, hold until accepted
	task automatic send_beat(input logic [1:0] cmd, input logic [SMP_BITS-1:0] smp);
		int gap;
		@(negedge clk);
		item_valid <= 1'b1;
		command <= cmd;
		sample <= smp;
		do
			@(posedge clk);
		while (item_stall);
		beats_sent++;
		// bursts of random length, then a random gap with junk on the bus
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
				command <= 2'($urandom);
				sample <= SMP_BITS'($urandom);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// classify probe: uniform or hugging one of the live thresholds
	function automatic logic [SMP_BITS-1:0] probe_sample();
		int t;
		if ($urandom_range(0, 1) == 0)
			return SMP_BITS'($urandom_range(0, SMP_MAX));
		t = int'(sb.thr[$urandom_range(0, 15)]) + $urandom_range(0, 2) - 1;
		if (t < 0)
			t = 0;
		if (t > SMP_MAX)
			t = SMP_MAX;
		return SMP_BITS'(t);
	endfunction

	// a calibration run of sixteen record beats, sometimes with classify
	// beats mixed in and sometimes broken off by a restore
	task automatic calib_run();
		int shape;
		int v;
		int abort_at;
		logic [SMP_BITS-1:0] fixed_v;
		shape = $urandom_range(0, 19);
		abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
		v = $urandom_range(0, 600);
		fixed_v = $urandom_range(0, 1) ? SMP_BITS'(SMP_MAX) : '0;
		for (int st = 0; st < 16; st++) begin
			if (st == abort_at) begin
				send_beat(CMD_RESTORE, SMP_BITS'($urandom));
				return;
			end
			if ($urandom_range(0, 6) == 0)
				send_beat(CMD_CLASSIFY, probe_sample());
			if (shape < 14) begin
				// ascending ladder readings
				v = v + $urandom_range(0, 260);
				if (v > SMP_MAX)
					v = SMP_MAX;
				send_beat(CMD_RECORD, SMP_BITS'(v));
			end else if (shape < 17) begin
				send_beat(CMD_RECORD, SMP_BITS'($urandom));
			end else begin
				send_beat(CMD_RECORD, fixed_v);
			end
		end
	endtask

	initial begin
		int pick;
		sb = new();
		beats_sent = 0;
		burst_left = $urandom_range(1, 40);
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = CMD_CLASSIFY;
		sample = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and the first default boundary
		send_beat(CMD_CLASSIFY, '0);
		send_beat(CMD_CLASSIFY, SMP_BITS'(SMP_MAX));
		send_beat(CMD_CLASSIFY, SMP_BITS'(1384));
		send_beat(CMD_SPARE, SMP_BITS'(2147));
		// a restore that aborts a partly recorded run
		send_beat(CMD_RECORD, SMP_BITS'(500));
		send_beat(CMD_RECORD, SMP_BITS'(700));
		send_beat(CMD_RESTORE, SMP_BITS'(SMP_MAX));
		// full run; stages 6 and 9 carry out-of-order samples that must be ignored
		for (int st = 0; st < 16; st++) begin
			if (st == 6 || st == 9)
				send_beat(CMD_RECORD, SMP_BITS'(SMP_MAX));
			else
				send_beat(CMD_RECORD, SMP_BITS'(1000 + st * 200));
		end
		// top threshold now sits below full scale: above all thresholds
		send_beat(CMD_CLASSIFY, SMP_BITS'(SMP_MAX));
		send_beat(CMD_CLASSIFY, '0);
		send_beat(CMD_RESTORE, '0);

		// random: mostly calibration runs and probes, some noise and restores
		while (beats_sent < RAND_BEATS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				calib_run();
			end else if (pick < 80) begin
				repeat ($urandom_range(4, 12))
					send_beat($urandom_range(0, 7) == 0 ? CMD_SPARE : CMD_CLASSIFY,
						probe_sample());
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 6))
					send_beat(2'($urandom), SMP_BITS'($urandom));
			end else begin
				send_beat(CMD_RESTORE, SMP_BITS'($urandom));
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;

		// drain, then a quiet stretch to catch stray result beats
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d beats: %0d classify, %0d record, %0d restore",
			beats_sent, sb.n_classify, sb.n_record, sb.n_restore);
		$display("%0d calibration completions, %0d result beats compared",
			sb.n_complete, sb.n_checked);
		if (sb.errors == 0) begin
			$display("calibrated_multilevel_line_decoder verification clean");
		end else begin
			$display("calibrated_multilevel_line_decoder verification failed");
		end
		$finish;
	end

endmodule
